// File: sv/ofrp_pkg.sv
package ofrp_pkg;

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_F     = 8'd102;
	localparam logic [7:0] CH_NUL   = 8'd0;

	typedef enum logic [8:0] {
		PH_LINE_START  = 9'b000000001,
		PH_SKIP        = 9'b000000010,
		PH_COL1        = 9'b000000100,
		PH_COL2        = 9'b000001000,
		PH_CORNER      = 9'b000010000,
		PH_VERT        = 9'b000100000,
		PH_AFTER_SLASH = 9'b001000000,
		PH_TEX         = 9'b010000000,
		PH_NORM        = 9'b100000000
	} ofrp_phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] text_byte;
	} ofrp_req_t;

	typedef struct packed {
		logic [31:0] vertex_index;
		logic [31:0] tex_index;
		logic        tex_given;
		logic [31:0] normal_index;
		logic        normal_given;
		logic        line_done;
	} ofrp_rec_t;

endpackage

// File: sv/ofrp_in_stage.sv
module ofrp_in_stage
	import ofrp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic      take,
	output ofrp_req_t req
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	assign req.valid     = valid_s1;
	assign req.text_byte = byte_s1;

endmodule

// File: sv/ofrp_core.sv
module ofrp_core
	import ofrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	output logic       emit,
	output ofrp_rec_t  rec
);

	ofrp_phase_t phase_q, phase_n;
	logic [31:0] acc_q, acc_n;
	logic        minus_q, minus_n;
	logic        fstart_q, fstart_n;
	logic [31:0] vhold_q, vhold_n;
	logic [31:0] thold_q, thold_n;
	logic        tflag_q, tflag_n;

	logic [31:0] bval;
	logic [31:0] acc_take;
	logic [31:0] fval;
	logic        ends;
	logic        is_nl;
	logic        lead_minus;
	logic        first_minus;

	assign bval        = {24'd0, text_byte} - {24'd0, CH_ZERO};
	assign acc_take    = (acc_q << 3) + (acc_q << 1) + bval;
	assign fval        = minus_q ? (32'd0 - acc_q) : acc_q;
	assign is_nl       = (text_byte == CH_NL);
	assign ends        = is_nl || (text_byte == CH_SPACE);
	assign lead_minus  = fstart_q && (text_byte == CH_MINUS);
	assign first_minus = (text_byte == CH_MINUS);

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		minus_n  = minus_q;
		fstart_n = fstart_q;
		vhold_n  = vhold_q;
		thold_n  = thold_q;
		tflag_n  = tflag_q;
		emit     = 1'b0;
		rec      = '0;
		rec.line_done = is_nl;
		unique case (phase_q)
			PH_LINE_START: begin
				if (text_byte == CH_F) begin
					phase_n = PH_COL1;
				end else if (!is_nl) begin
					phase_n = PH_SKIP;
				end
			end
			PH_COL1: begin
				phase_n = is_nl ? PH_LINE_START : PH_COL2;
			end
			PH_COL2: begin
				if (text_byte >= CH_ZERO && text_byte <= CH_NINE) begin
					tflag_n  = 1'b0;
					acc_n    = bval;
					minus_n  = 1'b0;
					fstart_n = 1'b0;
					phase_n  = PH_VERT;
				end else begin
					phase_n = is_nl ? PH_LINE_START : PH_SKIP;
				end
			end
			PH_CORNER: begin
				tflag_n = 1'b0;
				if (is_nl) begin
					phase_n = PH_LINE_START;
				end else if (text_byte == CH_NUL) begin
					phase_n = PH_SKIP;
				end else if (text_byte == CH_SPACE) begin
					vhold_n = '0;
					emit    = 1'b1;
				end else if (text_byte == CH_SLASH) begin
					vhold_n = '0;
					phase_n = PH_AFTER_SLASH;
				end else begin
					acc_n    = first_minus ? 32'd0 : bval;
					minus_n  = first_minus;
					fstart_n = 1'b0;
					phase_n  = PH_VERT;
				end
			end
			PH_VERT: begin
				if (ends) begin
					vhold_n = fval;
					emit    = 1'b1;
				end else if (text_byte == CH_SLASH) begin
					vhold_n = fval;
					phase_n = PH_AFTER_SLASH;
				end else begin
					if (lead_minus) begin
						minus_n = 1'b1;
					end else begin
						acc_n = acc_take;
					end
					fstart_n = 1'b0;
				end
			end
			PH_AFTER_SLASH: begin
				if (text_byte == CH_SLASH) begin
					tflag_n  = 1'b0;
					acc_n    = '0;
					minus_n  = 1'b0;
					fstart_n = 1'b1;
					phase_n  = PH_NORM;
				end else if (ends) begin
					emit          = 1'b1;
					rec.tex_given = 1'b1;
				end else begin
					acc_n    = first_minus ? 32'd0 : bval;
					minus_n  = first_minus;
					fstart_n = 1'b0;
					phase_n  = PH_TEX;
				end
			end
			PH_TEX: begin
				if (ends) begin
					emit          = 1'b1;
					rec.tex_given = 1'b1;
					rec.tex_index = fval;
				end else if (text_byte == CH_SLASH) begin
					thold_n  = fval;
					tflag_n  = 1'b1;
					acc_n    = '0;
					minus_n  = 1'b0;
					fstart_n = 1'b1;
					phase_n  = PH_NORM;
				end else begin
					if (lead_minus) begin
						minus_n = 1'b1;
					end else begin
						acc_n = acc_take;
					end
					fstart_n = 1'b0;
				end
			end
			PH_NORM: begin
				if (ends) begin
					emit             = 1'b1;
					rec.tex_given    = tflag_q;
					rec.tex_index    = tflag_q ? thold_q : 32'd0;
					rec.normal_given = 1'b1;
					rec.normal_index = fval;
				end else begin
					if (lead_minus) begin
						minus_n = 1'b1;
					end else begin
						acc_n = acc_take;
					end
					fstart_n = 1'b0;
				end
			end
			default: begin
				phase_n = is_nl ? PH_LINE_START : PH_SKIP;
			end
		endcase
		rec.vertex_index = vhold_n;
		if (emit) begin
			tflag_n = 1'b0;
			phase_n = is_nl ? PH_LINE_START : PH_CORNER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LINE_START;
			acc_q    <= '0;
			minus_q  <= 1'b0;
			fstart_q <= 1'b1;
			vhold_q  <= '0;
			thold_q  <= '0;
			tflag_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			minus_q  <= minus_n;
			fstart_q <= fstart_n;
			vhold_q  <= vhold_n;
			thold_q  <= thold_n;
			tflag_q  <= tflag_n;
		end
	end

`ifndef ASSERT_OFF
	a_emit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |-> phase_q == PH_CORNER || phase_q == PH_VERT ||
			phase_q == PH_AFTER_SLASH || phase_q == PH_TEX || phase_q == PH_NORM)
		else $error("record from a phase that cannot end a corner");
	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && rec.line_done |=> phase_q == PH_LINE_START)
		else $error("newline record did not return to line start");
	a_norm_src: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && rec.normal_given |-> phase_q == PH_NORM)
		else $error("normal given outside normal field");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(acc_q) && $stable(vhold_q))
		else $error("parser state moved without a byte");
`endif

endmodule

// File: sv/ofrp_out_stage.sv
module ofrp_out_stage
	import ofrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load_valid,
	input  ofrp_rec_t   rec,
	output logic        open_slot,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] vertex_index, [63:32] tex_index, [95:64] normal_index
	output logic [1:0]  m_tuser,   // [0] tex_given, [1] normal_given
	output logic        m_tlast
);

	logic        valid_s2;
	ofrp_rec_t   rec_s2;

	assign open_slot = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (open_slot) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (open_slot && load_valid) begin
			rec_s2 <= rec;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {rec_s2.normal_index, rec_s2.tex_index, rec_s2.vertex_index};
	assign m_tuser  = {rec_s2.normal_given, rec_s2.tex_given};
	assign m_tlast  = rec_s2.line_done;

endmodule

// File: sv/obj_face_record_parser.sv
// Path: an accepted byte waits in the input register; the corner parser
// decodes it once the output slot is open, and a record that it completes is
// registered in the output register and driven on m_tdata. Throughput:
// one text byte per cycle unless a held record with m_tready low stalls
// the input; the parser registers field accumulator and line phase per byte.
// Reset (arst_n low, asynchronous): clears the input and output valid flags
// and returns the parser to the start of a line with empty fields.
module obj_face_record_parser
	import ofrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] vertex_index, [63:32] tex_index, [95:64] normal_index
	output logic [1:0]  m_tuser,   // [0] tex_given, [1] normal_given
	output logic        m_tlast    // line_done
);

	ofrp_req_t req;
	ofrp_rec_t rec;
	logic      open_slot;
	logic      take;
	logic      emit;

	assign take = req.valid && open_slot;

	ofrp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.req      (req)
	);

	ofrp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (take),
		.text_byte (req.text_byte),
		.emit      (emit),
		.rec       (rec)
	);

	ofrp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (take && emit),
		.rec        (rec),
		.open_slot  (open_slot),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
